[hdl/lsp_pkg.sv]
// ---------------------------------------------------------------------------
// lsp_pkg - shared definitions for the looping sample player
// Command codes, register indexes and field widths used by the core.
// ---------------------------------------------------------------------------
`default_nettype none

package lsp_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 12;
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 13;
    localparam int PASS_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int FRAME_W  = 2 * SAMPLE_W;

    // Command codes carried on the input tuser
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_END    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LIMIT  = 2'd3;

endpackage

`default_nettype wire

[hdl/lsp_ram.sv]
// ---------------------------------------------------------------------------
// lsp_ram - generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ---------------------------------------------------------------------------
`default_nettype none

module lsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/looping_sample_player_core.sv]
// ---------------------------------------------------------------------------
// looping_sample_player_core - stereo sample playback voice with loop points
//
// One input stream carries commands on s_axis_tuser: load writes one stereo
// frame into sample memory, restart rewinds playback, play emits one frame.
// Only play beats produce an output beat on the m_axis channel; load and
// restart beats are absorbed. The cfg channel writes frame_count,
// loop_start, loop_end and loop_limit; it is always ready. It must be
// written only while the core is idle; the core does not enforce this.
// Throughput: one input beat per cycle while m_axis is not stalled. A play
// beat passes the RAM read stage and then the output register before it
// is shown on m_axis. Position and loop state update at acceptance and
// issue the sample memory read; the registered RAM data then loads the
// output register.
// When the receiver stalls, the output register holds its beat and one more
// play beat may sit in the RAM read stage; after that s_axis_tready drops.
// Reset (aresetn low, synchronous) clears position, pass counter, looping,
// the registers and the pipeline valids. Sample memory is not cleared; a
// frame must be loaded before it is played.
// ---------------------------------------------------------------------------
`default_nettype none

module looping_sample_player_core
    import lsp_pkg::*;
#(
    parameter int FRAME_DEPTH = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [47:0]           s_axis_tdata,  // load_addr[11:0], load_left[27:12],
                                                      // load_right[43:28], zero pad
    input  wire logic [CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
    // Output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [FRAME_W-1:0]         m_axis_tdata,  // left_out[15:0], right_out[31:16]
    output logic [0:0]                 m_axis_tuser,  // finished[0]
    // Configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    // End of sound never exceeds the memory depth
    localparam logic [POS_W-1:0] DEPTH_CAP =
        (FRAME_DEPTH > 8191) ? {POS_W{1'b1}} : POS_W'(FRAME_DEPTH);

    // Input fields
    logic [CMD_W-1:0]    in_cmd;
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_left;
    logic [SAMPLE_W-1:0] in_right;

    assign in_cmd   = s_axis_tuser;
    assign in_addr  = s_axis_tdata[11:0];
    assign in_left  = s_axis_tdata[27:12];
    assign in_right = s_axis_tdata[43:28];

    // Configuration registers
    logic [POS_W-1:0]  frame_count_reg;
    logic [POS_W-1:0]  loop_start_reg;
    logic [POS_W-1:0]  loop_end_reg;
    logic [PASS_W-1:0] loop_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            loop_start_reg  <= '0;
            loop_end_reg    <= '0;
            loop_limit_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_COUNT: frame_count_reg <= cfg_data[POS_W-1:0];
                REG_LOOP_START:  loop_start_reg  <= cfg_data[POS_W-1:0];
                REG_LOOP_END:    loop_end_reg    <= cfg_data[POS_W-1:0];
                REG_LOOP_LIMIT:  loop_limit_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline control
    logic s1_valid_reg;
    logic s1_finished_reg;
    logic out_adv;
    logic in_fire;
    logic play_fire;

    assign out_adv       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign play_fire     = in_fire && (in_cmd == CMD_PLAY);

    // Playback state
    logic [POS_W-1:0]  position_reg, position_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              active_reg, active_next;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  pos_chk;
    logic              play_fin;

    assign end_pos = (frame_count_reg > DEPTH_CAP) ? DEPTH_CAP : frame_count_reg;

    // Restart rewind, or loop check, end check and advance for an accepted play beat
    always_comb begin
        position_next = position_reg;
        pass_next     = pass_reg;
        active_next   = active_reg;
        pos_chk       = position_reg;
        play_fin      = 1'b0;
        if (in_fire && in_cmd == CMD_RESTART) begin
            position_next = '0;
            pass_next     = '0;
            active_next   = (loop_start_reg != '0);
        end else if (play_fire) begin
            if (active_reg && (loop_start_reg < loop_end_reg)
                    && (position_reg >= loop_end_reg)) begin
                pos_chk   = loop_start_reg;
                pass_next = pass_reg + PASS_W'(1);
                if ((loop_limit_reg != '0) && (pass_next >= loop_limit_reg)) begin
                    active_next = 1'b0;
                end
            end
            play_fin = (pos_chk >= end_pos);
            position_next = play_fin ? pos_chk : pos_chk + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            pass_reg     <= '0;
            active_reg   <= 1'b0;
        end else begin
            position_reg <= position_next;
            pass_reg     <= pass_next;
            active_reg   <= active_next;
        end
    end

    // Sample memory: load writes, play reads
    logic               ram_we;
    logic               ram_re;
    logic [FRAME_W-1:0] ram_rdata;

    assign ram_we = in_fire && (in_cmd == CMD_LOAD) && (32'(in_addr) < FRAME_DEPTH);
    assign ram_re = play_fire;

    lsp_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (FRAME_DEPTH)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (AW'(in_addr)),
        .wdata ({in_left, in_right}),
        .re    (ram_re),
        .raddr (AW'(pos_chk)),
        .rdata (ram_rdata)
    );

    // Read stage: track the beat whose RAM data is arriving
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (play_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (out_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (play_fire) begin
            s1_finished_reg <= play_fin;
        end
    end

    // Output register: load from the read stage when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tvalid <= 1'b0;
        end else if (out_adv) begin
            m_axis_tvalid <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && s1_valid_reg) begin
            if (s1_finished_reg) begin
                m_axis_tdata <= '0;
            end else begin
                m_axis_tdata <= {ram_rdata[SAMPLE_W-1:0], ram_rdata[FRAME_W-1:SAMPLE_W]};
            end
            m_axis_tuser <= s1_finished_reg;
        end
    end

    // Checks
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_adv |=> s1_valid_reg)
        else $error("read stage dropped a beat under stall");

    a_play_loads_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        play_fire |=> s1_valid_reg)
        else $error("accepted play beat did not enter the read stage");

    a_finished_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("finished beat carries nonzero samples");

endmodule

`default_nettype wire
